>>> design/ddh_pkg.sv
// ----------------------------------------------------------------------------
// Distance and heading PID package
// Shared widths, action codes and register indexes.
// ----------------------------------------------------------------------------
package ddh_pkg;
  localparam logic [1:0] ACT_FORWARD = 2'd0;
  localparam logic [1:0] ACT_TURN    = 2'd1;
  localparam logic [1:0] ACT_RESET   = 2'd2;
  localparam logic [1:0] ACT_STOP    = 2'd3;

  localparam logic [2:0] REG_FWD_P = 3'd0;
  localparam logic [2:0] REG_FWD_I = 3'd1;
  localparam logic [2:0] REG_FWD_D = 3'd2;
  localparam logic [2:0] REG_ROT_P = 3'd3;
  localparam logic [2:0] REG_ROT_I = 3'd4;
  localparam logic [2:0] REG_ROT_D = 3'd5;
  localparam logic [2:0] REG_SCALE = 3'd6;

  localparam int MAG_W  = 49;  // operand magnitude, saturated at 2^48
  localparam int GMAG_W = 32;  // gain magnitude, at most 2^31
  localparam int PROD_W = MAG_W + GMAG_W;

  localparam logic signed [63:0] FULL_SCALE = 64'sd65536;
  localparam logic signed [63:0] FWD_GATE   = 64'sd1572864;
  localparam logic signed [63:0] ROT_GATE   = 64'sd983040;
  localparam logic signed [63:0] SUM_MAX    = 64'sd140737488355327;
  localparam logic signed [63:0] I32_MAX    = 64'sd2147483647;
  localparam logic signed [63:0] I32_MIN    = -64'sd2147483648;
  localparam logic [63:0]        TERM_MAX   = 64'd1099511627776;
endpackage

>>> design/ddh_sermul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-and-add multiply, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddh_sermul
  import ddh_pkg::*;
#(
  parameter int AW = 49,
  parameter int BW = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [AW-1:0]     a,
  input  logic [BW-1:0]     b,
  output logic              done,
  output logic [AW+BW-1:0]  prod
);
  localparam int CW = $clog2(BW + 1);
  logic [AW+BW-1:0] acc;
  logic [AW+BW-1:0] mcand;
  logic [BW-1:0]    mplier;
  logic [CW-1:0]    cnt;
  logic             run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run    <= 1'b1;
        acc    <= '0;
        mcand  <= {{BW{1'b0}}, a};
        mplier <= b;
        cnt    <= CW'(BW);
      end else if (run) begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

  assert property (@(posedge clk) disable iff (rst) done |-> !run)
    else $error("multiplier done while running");
  assert property (@(posedge clk) disable iff (rst) start |=> run)
    else $error("multiplier did not start");
  assert property (@(posedge clk) disable iff (rst) run |-> cnt != '0)
    else $error("multiplier count underflow");
endmodule

>>> design/drive_distance_heading_pid.sv
// ----------------------------------------------------------------------------
// Distance and heading PID for a differential drive
// One control tick per word; up to six gain products through one serial multiplier.
// ----------------------------------------------------------------------------
// The input channel (in_valid / in_stall) carries one tick: action, target,
// output limit, both encoder counts and the gyro heading. The output channel
// (out_valid / out_stall) returns one word of left and right drive per tick.
// Gains and the position scale are written through cfg_we / cfg_index /
// cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce this. A drive-forward word takes two scale
// products and six gain products on the shared 32-step bit-serial
// multiplier, plus setup and mixing. A turn word takes two gain products;
// reset and stop words do not use the multiplier. One tick is worked on at
// a time; the next tick is accepted once the word has been taken.
// Reset clears the loop state, sets the gains to zero, the scale to 1.0 and
// the peak limit to full scale. While the receiver stalls, the result stays
// in the output register; in_stall stays high until it has been taken.
// ----------------------------------------------------------------------------
module drive_distance_heading_pid
  import ddh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic signed [31:0] target,
  input  logic [16:0]        output_limit,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  input  logic signed [31:0] gyro_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] left_drive,
  output logic signed [17:0] right_drive,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POSL = 3'd1;
  localparam logic [2:0] S_POSR = 3'd2;
  localparam logic [2:0] S_ERR  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_MIX  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [31:0] gain [6];
  logic [31:0] scale;
  logic [2:0]  state;
  logic [2:0]  term;
  logic [1:0]  act;
  logic signed [63:0] tgt, gyr, rcnt, lpos;
  logic signed [63:0] ferr, fsum, fdel, rerr, rsum, rdel;
  logic signed [63:0] fcmd, rcmd;
  logic signed [63:0] fprev, fsumr, rprev, rsumr, hold;
  logic        captured;
  logic [16:0] peak;
  logic [16:0] lim;
  logic signed [17:0] ld, rd;

  logic              m_start, m_done;
  logic [MAG_W-1:0]  m_a;
  logic [GMAG_W-1:0] m_b;
  logic [PROD_W-1:0] m_p;
  logic              m_neg;

  ddh_sermul #(.AW(MAG_W), .BW(GMAG_W)) u_mul (
    .clk(clk), .rst(rst), .start(m_start), .a(m_a), .b(m_b),
    .done(m_done), .prod(m_p)
  );

  function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Operand for the current gain term and its gain register.
  logic signed [63:0] opnd;
  logic [31:0]        gsel;
  logic [63:0]        omag;
  logic [31:0]        gmag;
  always_comb begin
    case (term)
      3'd0:    begin opnd = ferr; gsel = gain[0]; end
      3'd1:    begin opnd = fsum; gsel = gain[1]; end
      3'd2:    begin opnd = fdel; gsel = gain[2]; end
      3'd3:    begin opnd = rerr; gsel = gain[3]; end
      3'd4:    begin opnd = rsum; gsel = gain[4]; end
      default: begin opnd = rdel; gsel = gain[5]; end
    endcase
    omag = opnd[63] ? 64'(-opnd) : 64'(opnd);
    if (omag > 64'h1_0000_0000_0000) omag = 64'h1_0000_0000_0000;
    gmag = gsel[31] ? 32'(-gsel) : gsel;
  end

  // Term from the product: (|a|*|g|) >> 16, saturated at 2^40, signed.
  logic [63:0]        pshift;
  logic signed [63:0] tval;
  always_comb begin
    pshift = 64'(m_p >> 16);
    if (pshift > TERM_MAX) pshift = TERM_MAX;
    tval = m_neg ? -$signed(pshift) : $signed(pshift);
  end

  logic signed [63:0] scl_prod;
  assign scl_prod = m_neg ? -$signed(64'(m_p)) : $signed(64'(m_p));

  logic signed [63:0] lmix, rmix, pk;
  always_comb begin
    pk   = $signed({47'd0, peak});
    lmix = sat64(fcmd - rcmd, -pk, pk);
    rmix = sat64(fcmd + rcmd, -pk, pk);
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      m_start   <= 1'b0;
      for (int i = 0; i < 6; i++) gain[i] <= '0;
      scale     <= 32'd16777216;
      captured  <= 1'b0;
      hold      <= '0;
      fprev     <= '0;
      fsumr     <= '0;
      rprev     <= '0;
      rsumr     <= '0;
      peak      <= 17'd65536;
    end else begin
      m_start <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_SCALE) scale <= cfg_data;
        else if (cfg_index < REG_SCALE) gain[cfg_index] <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act  <= action;
            tgt  <= 64'(target);
            gyr  <= 64'(gyro_heading);
            rcnt <= 64'(right_count);
            lim  <= output_limit;
            fcmd <= '0;
            rcmd <= '0;
            case (action)
              ACT_FORWARD: begin
                m_a     <= MAG_W'(left_count[31] ? 33'(-64'(left_count))
                                                 : 33'(left_count));
                m_b     <= scale;
                m_neg   <= left_count[31];
                m_start <= 1'b1;
                state   <= S_POSL;
              end
              ACT_TURN: state <= S_ERR;
              ACT_RESET: begin
                captured <= 1'b0;
                hold     <= '0;
                fprev    <= '0;
                fsumr    <= '0;
                rprev    <= '0;
                rsumr    <= '0;
                state    <= S_MIX;
              end
              default: state <= S_MIX;
            endcase
          end
        end
        S_POSL: if (m_done) begin
          lpos    <= scl_prod >>> 8;
          m_a     <= MAG_W'(rcnt[63] ? 64'(-rcnt) : 64'(rcnt));
          m_neg   <= rcnt[63];
          m_start <= 1'b1;
          state   <= S_POSR;
        end
        S_POSR: if (m_done) begin
          logic signed [63:0] rp, e, s, hh;
          rp = scl_prod >>> 8;
          e  = sat64(tgt - ((lpos + rp) >>> 1), I32_MIN, I32_MAX);
          ferr <= e;
          s  = (e < FWD_GATE) ? sat64(fsumr + e * 50, -SUM_MAX, SUM_MAX) : 64'sd0;
          fsum  <= s;
          fsumr <= s;
          fdel  <= (e - fprev) * 50;
          fprev <= e;
          peak  <= (lim > 17'd65536) ? 17'd65536 : lim;
          hh = captured ? hold : sat64(gyr + FULL_SCALE, I32_MIN, I32_MAX);
          hold     <= hh;
          captured <= 1'b1;
          e  = sat64(hh - gyr, I32_MIN, I32_MAX);
          rerr <= e;
          s  = (e < ROT_GATE) ? sat64(rsumr + e * 50, -SUM_MAX, SUM_MAX) : 64'sd0;
          rsum  <= s;
          rsumr <= s;
          rdel  <= e - rprev;
          rprev <= e;
          term  <= 3'd0;
          state <= S_ERR;
        end
        S_ERR: begin
          if (act == ACT_TURN) begin
            logic signed [63:0] e;
            e = sat64(tgt - gyr, I32_MIN, I32_MAX);
            rerr  <= e;
            rdel  <= e - rprev;
            rprev <= e;
            term  <= 3'd3;
            state <= S_ERR;
            act   <= ACT_STOP;  // marks turn setup as done
          end else begin
            m_a     <= omag[MAG_W-1:0];
            m_b     <= gmag;
            m_neg   <= (opnd[63] != gsel[31]);
            m_start <= 1'b1;
            state   <= S_MUL;
          end
        end
        S_MUL: if (m_done) begin
          if (term < 3'd3) fcmd <= fcmd + tval;
          else rcmd <= rcmd + tval;
          if (term == 3'd5) state <= S_MIX;
          else begin
            // A turn tick skips the heading integral term.
            term  <= (term == 3'd3 && act == ACT_STOP) ? 3'd5 : term + 3'd1;
            state <= S_ERR;
          end
        end
        S_MIX: begin
          ld        <= 18'(lmix);
          rd        <= 18'(rmix);
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        default: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign left_drive  = ld;
  assign right_drive = rd;

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk) disable iff (rst) peak <= 17'd65536)
    else $error("peak limit out of range");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && out_stall |=> out_valid && $stable(ld))
    else $error("stalled result changed");
endmodule
